@@ src/sfd_pkg.sv @@
// sfd_pkg: shared types and constants for the stereo feedback delay
// word layouts for the sample, result and line memory, register indexes
// no dependencies
package sfd_pkg;

    // default depth of each delay line, in samples
    localparam int LINE_DEPTH_DEF = 65536;

    // configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [CFG_IW-1:0] REG_MIX      = 2'd2;

    // feedback gain ceiling (0.95 in Q0.15) and unity in Q1.15
    localparam logic [14:0] FB_MAX  = 15'd31130;
    localparam logic [15:0] MIX_ONE = 16'h8000;

    typedef struct packed {
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } out_word_t;

    // one entry of the line memory holds both channels
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } line_word_t;

    localparam int LINE_W = $bits(line_word_t);

endpackage

@@ src/stereo_feedback_delay.sv @@
// stereo_feedback_delay: stereo echo with shared circular delay lines and feedback
// a result word passes the address, read-return and product stages, then the result queue
// words are spaced by the single write port of the line memory (feedback tap and new
//   sample per word); a delay_length write holds off words until its reduction ends
// reset: no clearing pass; a fill pointer makes unwritten entries read as zero
// depends on sfd_pkg and sfd_ram
module stereo_feedback_delay #(
    parameter int LINE_DEPTH = sfd_pkg::LINE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        src_valid,
    output logic                        src_ready,
    input  sfd_pkg::in_word_t           src_word,
    output logic                        dst_valid,
    input  logic                        dst_ready,
    output sfd_pkg::out_word_t          dst_word,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sfd_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [sfd_pkg::CFG_DW-1:0]  cfg_data
);

    // round half up at bit 15, then clamp to 16 bits
    function automatic logic signed [15:0] rnd_sat(input logic signed [32:0] v);
        logic signed [33:0] t;
        logic signed [18:0] q;
        t = 34'(v) + 34'sd16384;
        q = 19'(t >>> 15);
        if (q > 19'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (q < -19'sd32768)
        begin
            return 16'sh8000;
        end
        return 16'(q);
    endfunction

    localparam int AW        = $clog2(LINE_DEPTH);
    localparam int CMP_W     = ($clog2(LINE_DEPTH + 1) > 17) ? $clog2(LINE_DEPTH + 1) : 17;
    // floor(2^32 / depth): the quotient estimate is exact or one short
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(LINE_DEPTH));
    localparam int OQ_DEPTH  = 4;
    localparam int QW        = $clog2(OQ_DEPTH);
    localparam int PW        = $clog2(OQ_DEPTH + 1);

    // address stage: read issue and read return
    typedef struct packed {
        logic [AW-1:0]     rd;
        logic [AW-1:0]     wr;
        logic              ok;
        sfd_pkg::in_word_t smp;
    } addr_stage_t;

    // product stage
    typedef struct packed {
        logic [AW-1:0]      rd;
        logic [AW-1:0]      wr;
        sfd_pkg::in_word_t  smp;
        logic signed [32:0] pf_l;
        logic signed [32:0] pf_r;
        logic signed [32:0] pdry_l;
        logic signed [32:0] pwet_l;
        logic signed [32:0] pdry_r;
        logic signed [32:0] pwet_r;
    } prod_stage_t;

    // write-back stages
    typedef struct packed {
        logic [AW-1:0]       rd;
        logic [AW-1:0]       wr;
        sfd_pkg::line_word_t f;
        sfd_pkg::line_word_t w;
    } wb_stage_t;

    typedef struct packed {
        logic [AW-1:0]       wr;
        sfd_pkg::line_word_t w;
    } tail_stage_t;

    typedef struct packed {
        logic [AW-1:0]       addr;
        sfd_pkg::line_word_t data;
    } mem_wr_t;

    // configuration state
    logic [15:0]    rem_reg, rem_next;        // delay_length modulo depth
    logic [15:0]    quo_reg, quo_next;        // estimated delay / depth
    logic [1:0]     step_reg, step_next;
    logic           busy_reg, busy_next;
    logic [14:0]    fb_reg, fb_next;
    logic [15:0]    mix_reg, mix_next;
    logic [15:0]    dry_reg, dry_next;
    logic [15:0]    quo_est;
    logic [15:0]    quo_back;

    // write pointer and fill tracking
    logic [AW-1:0]  wpos_reg, wpos_next;
    logic           full_reg, full_next;

    // pipeline
    logic           s0_v_reg, s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    addr_stage_t    s0_reg, s0_next, s1_reg;
    prod_stage_t    s2_reg, s2_next;
    wb_stage_t      s3_reg, s3_next;
    tail_stage_t    s4_reg;

    // write port and the write of the previous cycle
    logic           wp_v;
    mem_wr_t        wp;
    logic           cap_v_reg;
    mem_wr_t        cap_reg;

    logic [AW:0]    diff;
    logic [AW-1:0]  rd_new;
    logic           in_acc;
    sfd_pkg::line_word_t ram_q, d_fwd;
    logic signed [16:0] fb_s, mix_s, dry_s;

    // result queue
    sfd_pkg::out_word_t ofifo_reg [OQ_DEPTH];
    sfd_pkg::out_word_t out_word_next;
    logic [QW-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [PW-1:0]  ocnt_reg, ocnt_next;
    logic [PW-1:0]  pend_reg, pend_next;      // accepted words not yet delivered
    logic           pop;

    // ---------------- configuration ----------------
    assign cfg_ready = !busy_reg;
    assign quo_est   = 16'((48'(rem_reg) * 48'(RECIP)) >> 32);
    assign quo_back  = 16'(32'(quo_reg) * 32'(LINE_DEPTH));

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        fb_next   = fb_reg;
        mix_next  = mix_reg;
        dry_next  = dry_reg;
        // delay reduced modulo depth in three steps: reciprocal estimate of the
        // quotient, subtract quotient times depth, then one final correction
        if (busy_reg)
        begin
            if (step_reg == 2'd2)
            begin
                quo_next = quo_est;
            end
            else if (step_reg == 2'd1)
            begin
                rem_next = rem_reg - quo_back;
            end
            else if (CMP_W'(rem_reg) >= CMP_W'(LINE_DEPTH))
            begin
                rem_next = rem_reg - 16'(LINE_DEPTH);
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sfd_pkg::REG_DELAY:
                begin
                    rem_next  = cfg_data;
                    step_next = 2'd2;
                    busy_next = 1'b1;
                end
                sfd_pkg::REG_FEEDBACK:
                begin
                    fb_next = (cfg_data[14:0] > sfd_pkg::FB_MAX) ? sfd_pkg::FB_MAX
                                                                 : cfg_data[14:0];
                end
                sfd_pkg::REG_MIX:
                begin
                    mix_next = (cfg_data > sfd_pkg::MIX_ONE) ? sfd_pkg::MIX_ONE : cfg_data;
                    dry_next = sfd_pkg::MIX_ONE - mix_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- accept and address generation ----------------
    // one word in the read stage at a time keeps words from entering back to back
    assign src_ready = !s0_v_reg && !busy_reg && (pend_reg != PW'(OQ_DEPTH));
    assign in_acc    = src_valid && src_ready;

    // read position = write pointer - delay, wrapped into the line
    assign diff   = {1'b0, wpos_reg} - {1'b0, AW'(rem_reg)};
    assign rd_new = diff[AW] ? (diff[AW-1:0] + AW'(LINE_DEPTH)) : diff[AW-1:0];

    always_comb
    begin
        wpos_next  = wpos_reg;
        full_next  = full_reg;
        s0_next.rd  = rd_new;
        s0_next.wr  = wpos_reg;
        // entry holds real data once the write pointer has passed it
        s0_next.ok  = full_reg || (rd_new < wpos_reg);
        s0_next.smp = src_word;
        if (in_acc)
        begin
            if (wpos_reg == AW'(LINE_DEPTH - 1))
            begin
                wpos_next = '0;
                full_next = 1'b1;
            end
            else
            begin
                wpos_next = wpos_reg + 1'b1;
            end
        end
    end

    // ---------------- line memory ----------------
    // only one write stage can be busy at a time; tap write goes first so
    // a zero delay leaves the new sample in place
    always_comb
    begin
        wp_v = s3_v_reg || s4_v_reg;
        if (s3_v_reg)
        begin
            wp.addr = s3_reg.rd;
            wp.data = s3_reg.f;
        end
        else
        begin
            wp.addr = s4_reg.wr;
            wp.data = s4_reg.w;
        end
    end

    sfd_ram #(
        .WIDTH (sfd_pkg::LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (wp_v),
        .wr_addr (wp.addr),
        .wr_data (wp.data),
        .rd_addr (s0_reg.rd),
        .rd_data (ram_q)
    );

    // ---------------- read return with forwarding ----------------
    // newest first: sample still waiting in the write-back stage, the write
    // going on now, the write of the read cycle, then the memory itself
    always_comb
    begin
        if (s3_v_reg && (s3_reg.wr == s1_reg.rd))
        begin
            d_fwd = s3_reg.w;
        end
        else if (wp_v && (wp.addr == s1_reg.rd))
        begin
            d_fwd = wp.data;
        end
        else if (cap_v_reg && (cap_reg.addr == s1_reg.rd))
        begin
            d_fwd = cap_reg.data;
        end
        else if (s1_reg.ok)
        begin
            d_fwd = ram_q;
        end
        else
        begin
            d_fwd = '0;
        end
    end

    assign fb_s  = {2'b00, fb_reg};
    assign mix_s = {1'b0, mix_reg};
    assign dry_s = {1'b0, dry_reg};

    always_comb
    begin
        s2_next.rd     = s1_reg.rd;
        s2_next.wr     = s1_reg.wr;
        s2_next.smp    = s1_reg.smp;
        s2_next.pf_l   = d_fwd.left * fb_s;
        s2_next.pf_r   = d_fwd.right * fb_s;
        s2_next.pdry_l = s1_reg.smp.left_in * dry_s;
        s2_next.pwet_l = d_fwd.left * mix_s;
        s2_next.pdry_r = s1_reg.smp.right_in * dry_s;
        s2_next.pwet_r = d_fwd.right * mix_s;
    end

    // ---------------- round, saturate, mix ----------------
    // in + round(p) folds into one rounding of (in << 15) + p
    always_comb
    begin
        s3_next.rd      = s2_reg.rd;
        s3_next.wr      = s2_reg.wr;
        s3_next.f.left  = rnd_sat(s2_reg.pf_l);
        s3_next.f.right = rnd_sat(s2_reg.pf_r);
        s3_next.w.left  = rnd_sat((33'(s2_reg.smp.left_in) <<< 15) + s2_reg.pf_l);
        s3_next.w.right = rnd_sat((33'(s2_reg.smp.right_in) <<< 15) + s2_reg.pf_r);
        out_word_next.left_out  = rnd_sat(s2_reg.pdry_l + s2_reg.pwet_l);
        out_word_next.right_out = rnd_sat(s2_reg.pdry_r + s2_reg.pwet_r);
    end

    // ---------------- result queue ----------------
    assign dst_valid = (ocnt_reg != '0);
    assign dst_word  = ofifo_reg[head_reg];
    assign pop       = dst_valid && dst_ready;

    always_comb
    begin
        head_next = pop ? head_reg + 1'b1 : head_reg;
        tail_next = s2_v_reg ? tail_reg + 1'b1 : tail_reg;
        ocnt_next = ocnt_reg;
        if (s2_v_reg && !pop)
        begin
            ocnt_next = ocnt_reg + 1'b1;
        end
        else if (!s2_v_reg && pop)
        begin
            ocnt_next = ocnt_reg - 1'b1;
        end
        pend_next = pend_reg;
        if (in_acc && !pop)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!in_acc && pop)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= 16'd1;
            quo_reg   <= '0;
            step_reg  <= '0;
            busy_reg  <= 1'b0;
            fb_reg    <= '0;
            mix_reg   <= '0;
            dry_reg   <= sfd_pkg::MIX_ONE;
            wpos_reg  <= '0;
            full_reg  <= 1'b0;
            s0_v_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            cap_v_reg <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            ocnt_reg  <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            step_reg  <= step_next;
            busy_reg  <= busy_next;
            fb_reg    <= fb_next;
            mix_reg   <= mix_next;
            dry_reg   <= dry_next;
            wpos_reg  <= wpos_next;
            full_reg  <= full_next;
            s0_v_reg  <= in_acc;
            s1_v_reg  <= s0_v_reg;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            cap_v_reg <= wp_v;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            ocnt_reg  <= ocnt_next;
            pend_reg  <= pend_next;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s0_reg <= s0_next;
        end
        s1_reg    <= s0_reg;
        s2_reg    <= s2_next;
        s3_reg    <= s3_next;
        s4_reg.wr <= s3_reg.wr;
        s4_reg.w  <= s3_reg.w;
        cap_reg   <= wp;
        if (s2_v_reg)
        begin
            ofifo_reg[tail_reg] <= out_word_next;
        end
    end

    // ---------------- assertions ----------------
    // the single write port is never claimed by both write stages
    a_wport: assert property (@(posedge clk) disable iff (!rst_n)
        !(s3_v_reg && s4_v_reg))
        else $error("line memory write port double-booked");

    // words never enter the pipeline back to back
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        s0_v_reg |=> !s0_v_reg)
        else $error("words entered back to back");

    // a finished result always finds room in the queue
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        s2_v_reg |-> (ocnt_reg != PW'(OQ_DEPTH)))
        else $error("result queue overflow");

    // queued results never exceed words still owed
    a_owed: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= pend_reg)
        else $error("result queue holds more than outstanding words");

    // the reduced delay lies inside the line once the reduction ends
    a_mod: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> (CMP_W'(rem_reg) < CMP_W'(LINE_DEPTH)))
        else $error("delay not reduced below line depth");

endmodule

@@ src/sfd_ram.sv @@
// sfd_ram: generic simple dual-port RAM, one write and one registered read port
// a read at the address being written returns the old contents
// depends on sfd_pkg for default sizes
module sfd_ram #(
    parameter int WIDTH = sfd_pkg::LINE_W,
    parameter int DEPTH = sfd_pkg::LINE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ tb/sv/stereo_feedback_delay_tb.sv @@
// stereo_feedback_delay_tb: self-checking testbench for the stereo echo block
// drives sample words and register writes, predicts every mixed word, checks field by field
// depends on sfd_pkg and stereo_feedback_delay
module stereo_feedback_delay_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = sfd_pkg::LINE_DEPTH_DEF;

    // index with no register behind it, writes there must be dropped
    localparam logic [sfd_pkg::CFG_IW-1:0] REG_NONE = 2'd3;

    // gap and stall draws run from zero up to this many cycles
    localparam int unsigned MAX_IDLE = 17;

    // random part: phases with fresh settings, samples per phase
    localparam int RAND_PHASES = 12;
    localparam int PHASE_WORDS = 118;

    // every tb-driven signal starts known
    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         src_valid = 1'b0;
    logic                         src_ready;
    sfd_pkg::in_word_t            src_word  = '0;
    logic                         dst_valid;
    logic                         dst_ready = 1'b0;
    sfd_pkg::out_word_t           dst_word;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [sfd_pkg::CFG_IW-1:0]   cfg_index = '0;
    logic [sfd_pkg::CFG_DW-1:0]   cfg_data  = '0;

    // sample words waiting for the driver, mixed words waiting for the block
    sfd_pkg::in_word_t   pending_samples[$];
    sfd_pkg::out_word_t  expected_mix[$];

    // shadow of the block: both delay lines (cleared), write pointer, registers
    bit signed [15:0]    left_tap [DEPTH];
    bit signed [15:0]    right_tap[DEPTH];
    int unsigned         wr_pos    = 0;
    logic [15:0]         delay_len = 16'd1;
    logic [14:0]         fb_gain   = '0;
    logic [15:0]         wet_share = '0;

    // when set, that side runs with no gaps or stalls for the current phase
    bit                  src_calm  = 1'b0;
    bit                  dst_calm  = 1'b0;

    int                  fail_count = 0;

    int unsigned         src_gap   = 0;
    int unsigned         dst_stall = 0;

    stereo_feedback_delay u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_word  (dst_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // add half an lsb and shift down, halves go toward plus infinity
    function automatic longint round_q15(input longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic int unsigned draw_idle(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // one accepted sample word: update both lines and queue the mixed word
    task automatic predict_echo(input sfd_pkg::in_word_t w);
        int unsigned        rd;
        longint             fb;
        longint             mix;
        longint             dl;
        longint             dr;
        longint             fl;
        longint             fr;
        longint             xl;
        longint             xr;
        sfd_pkg::out_word_t o;
        // gains above their ceilings are clamped, delay wraps on the depth
        fb  = (fb_gain > sfd_pkg::FB_MAX) ? sfd_pkg::FB_MAX : fb_gain;
        mix = (wet_share > sfd_pkg::MIX_ONE) ? sfd_pkg::MIX_ONE : wet_share;
        rd  = (wr_pos + DEPTH - (delay_len % DEPTH)) % DEPTH;
        xl  = $signed(w.left_in);
        xr  = $signed(w.right_in);
        dl  = left_tap[rd];
        dr  = right_tap[rd];
        fl  = round_q15(dl * fb);
        fr  = round_q15(dr * fb);
        // tap is rewritten with feedback first, so a zero delay lets the new
        // sample land on top of it
        left_tap[rd]      = clamp16(fl);
        right_tap[rd]     = clamp16(fr);
        left_tap[wr_pos]  = clamp16(xl + fl);
        right_tap[wr_pos] = clamp16(xr + fr);
        o.left_out  = clamp16(round_q15(xl * (longint'(32768) - mix) + dl * mix));
        o.right_out = clamp16(round_q15(xr * (longint'(32768) - mix) + dr * mix));
        expected_mix.push_back(o);
        wr_pos = (wr_pos + 1) % DEPTH;
    endtask

    // sample driver: holds valid until accepted, then waits its drawn gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_word  <= '0;
            src_gap   <= 0;
        end
        else
        begin
            if (src_valid && src_ready)
                predict_echo(src_word);
            // slot is free after this edge, either empty or just taken
            if (!src_valid || src_ready)
            begin
                if (src_gap != 0)
                begin
                    src_valid <= 1'b0;
                    src_gap   <= src_gap - 1;
                end
                else if (pending_samples.size() != 0)
                begin
                    src_valid <= 1'b1;
                    src_word  <= pending_samples.pop_front();
                    src_gap   <= draw_idle(src_calm);
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each taken word, then stalls for a drawn count
    always @(posedge clk or negedge rst_n)
    begin : mon_blk
        int unsigned        stall_n;
        sfd_pkg::out_word_t want;
        if (!rst_n)
        begin
            dst_ready <= 1'b0;
            dst_stall <= 0;
        end
        else
        begin
            stall_n = dst_stall;
            if (dst_valid && dst_ready)
            begin
                if (expected_mix.size() == 0)
                begin
                    $error("unexpected mixed word %h with nothing pending", dst_word);
                    fail_count++;
                end
                else
                begin
                    want = expected_mix.pop_front();
                    if (dst_word.left_out !== want.left_out)
                    begin
                        $error("left_out: expected %0d, got %0d",
                               want.left_out, dst_word.left_out);
                        fail_count++;
                    end
                    if (dst_word.right_out !== want.right_out)
                    begin
                        $error("right_out: expected %0d, got %0d",
                               want.right_out, dst_word.right_out);
                        fail_count++;
                    end
                end
                stall_n = draw_idle(dst_calm);
            end
            if (stall_n != 0)
            begin
                dst_ready <= 1'b0;
                dst_stall <= stall_n - 1;
            end
            else
            begin
                dst_ready <= 1'b1;
                dst_stall <= 0;
            end
        end
    end

    // register write, only issued while the block is drained
    task automatic write_reg(input logic [sfd_pkg::CFG_IW-1:0] idx,
                             input logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            sfd_pkg::REG_DELAY:    delay_len = data;
            sfd_pkg::REG_FEEDBACK: fb_gain   = data[14:0];
            sfd_pkg::REG_MIX:      wet_share = data;
            default:               ;
        endcase
    endtask

    // wait until every queued sample is taken and every mixed word is back
    task automatic wait_drained();
        while (pending_samples.size() != 0 || src_valid || expected_mix.size() != 0)
            @(posedge clk);
    endtask

    task automatic queue_pair(input logic [15:0] l, input logic [15:0] r);
        sfd_pkg::in_word_t w;
        w.left_in  = l;
        w.right_in = r;
        pending_samples.push_back(w);
    endtask

    // random sample, shifted down for quieter phases so feedback can build
    function automatic logic [15:0] rand_sample(input int unsigned shift);
        logic signed [15:0] s;
        s = 16'($urandom);
        return s >>> shift;
    endfunction

    initial
    begin : stim_blk
        int unsigned shift;
        logic [15:0] fb_val;
        logic [15:0] mix_val;
        logic [15:0] dly_val;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: delay one, no feedback, fully dry, so output equals input
        src_calm = 1'b1;
        dst_calm = 1'b1;
        queue_pair(16'h7fff, 16'h8000);
        queue_pair(16'h8000, 16'h7fff);
        queue_pair(16'h0000, 16'hffff);
        queue_pair(16'hffff, 16'h0000);
        queue_pair(16'h0001, 16'h0001);
        wait_drained();

        // zero delay, feedback and mix both written above their ceilings
        src_calm = 1'b0;
        dst_calm = 1'b0;
        write_reg(sfd_pkg::REG_DELAY, 16'd0);
        write_reg(sfd_pkg::REG_FEEDBACK, 16'hffff);
        write_reg(sfd_pkg::REG_MIX, 16'hffff);
        queue_pair(16'h7fff, 16'h8000);
        queue_pair(16'h7fff, 16'h8000);
        queue_pair(16'h8000, 16'h7fff);
        queue_pair(16'd12345, 16'hef1f);
        wait_drained();

        // write to the unused index must change nothing
        write_reg(REG_NONE, 16'hffff);
        write_reg(sfd_pkg::REG_DELAY, 16'd2);
        write_reg(sfd_pkg::REG_FEEDBACK, 16'(sfd_pkg::FB_MAX));
        write_reg(sfd_pkg::REG_MIX, sfd_pkg::MIX_ONE);
        // full-scale pulses at maximum feedback push the lines into saturation
        repeat (4) queue_pair(16'h8000, 16'h7fff);
        repeat (2) queue_pair(16'h0000, 16'h0000);
        wait_drained();

        // longest delay reads entries far behind the pointer, half wet
        write_reg(sfd_pkg::REG_DELAY, 16'hffff);
        write_reg(sfd_pkg::REG_FEEDBACK, 16'h7fff);
        write_reg(sfd_pkg::REG_MIX, 16'h4000);
        queue_pair(16'h7fff, 16'h8000);
        queue_pair(16'h8000, 16'h7fff);
        queue_pair(16'h4000, 16'hbfff);
        wait_drained();

        // random phases: fresh settings each time, mostly short delays so echoes return
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            wait_drained();
            src_calm = ($urandom_range(0, 3) == 0);
            dst_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: fb_val = 16'($urandom_range(0, 31130));
                1: fb_val = 16'($urandom_range(31131, 65535));
                2: fb_val = 16'($urandom);
                default: fb_val = 16'(sfd_pkg::FB_MAX);
            endcase
            case ($urandom_range(0, 3))
                0: mix_val = 16'($urandom_range(0, 32768));
                1: mix_val = sfd_pkg::MIX_ONE;
                2: mix_val = 16'($urandom_range(32769, 65535));
                default: mix_val = 16'd0;
            endcase
            case ($urandom_range(0, 4))
                0: dly_val = 16'($urandom_range(0, 8));
                1: dly_val = 16'($urandom_range(1, 200));
                2: dly_val = 16'($urandom);
                3: dly_val = 16'hffff;
                default: dly_val = 16'($urandom_range(1, 40));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_NONE, 16'($urandom));
            write_reg(sfd_pkg::REG_FEEDBACK, fb_val);
            write_reg(sfd_pkg::REG_MIX, mix_val);
            write_reg(sfd_pkg::REG_DELAY, dly_val);
            shift = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
            for (int i = 0; i < PHASE_WORDS; i++)
                queue_pair(rand_sample(shift), rand_sample(shift));
        end

        wait_drained();
        // room for any stray word the block might still offer
        repeat (20) @(posedge clk);

        if (fail_count == 0 && expected_mix.size() == 0)
            $display("stereo_feedback_delay_tb: PASS");
        else
            $display("stereo_feedback_delay_tb: FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("stereo_feedback_delay_tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
src/sfd_pkg.sv
src/sfd_ram.sv
src/stereo_feedback_delay.sv
tb/sv/stereo_feedback_delay_tb.sv
